/* hdl/pwc_pkg.sv */
// Shared types, register codes and the keyboard row lookup for the pattern checker.
package pwc_pkg;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 8;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_REPEAT     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SEQUENTIAL_MIN = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WALK_MIN       = 2'd2;

  // Reset values of the configuration registers
  localparam logic [CFG_DATA_BITS-1:0] MAX_REPEAT_RESET     = 8'd3;
  localparam logic [CFG_DATA_BITS-1:0] SEQUENTIAL_MIN_RESET = 8'd3;
  localparam logic [CFG_DATA_BITS-1:0] WALK_MIN_RESET       = 8'd4;

  // Class mask bit positions
  localparam int CLASS_LOWER  = 0;
  localparam int CLASS_UPPER  = 1;
  localparam int CLASS_DIGIT  = 2;
  localparam int CLASS_SYMBOL = 3;

  // Distance between upper and lower case in ASCII
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [CFG_DATA_BITS-1:0] max_repeat;
    logic [CFG_DATA_BITS-1:0] sequential_min;
    logic [CFG_DATA_BITS-1:0] walk_min;
  } cfg_t;

  typedef struct packed {
    logic       on_keyboard;
    logic [1:0] row;
    logic [3:0] col;
  } key_pos_t;

  // One classified character as handed from front to back
  typedef struct packed {
    logic       same;        // equal to the previous character
    logic       rise;        // previous code plus one
    logic       fall;        // previous code minus one
    logic       adjacent;    // neighbor key on the same row as the previous one
    logic [3:0] class_bits;  // one-hot class of this character
    logic       final_char;
  } item_t;

  // Find a character on the four keyboard rows, letters case folded
  function automatic key_pos_t key_lookup(input logic [7:0] c);
    logic [7:0] f;
    key_pos_t   p;
    f = (c >= "A" && c <= "Z") ? c + CASE_OFFSET : c;
    p.on_keyboard = 1'b1;
    p.row = 2'd0;
    p.col = 4'd0;
    unique case (f)
      "1": begin p.row = 2'd0; p.col = 4'd0; end
      "2": begin p.row = 2'd0; p.col = 4'd1; end
      "3": begin p.row = 2'd0; p.col = 4'd2; end
      "4": begin p.row = 2'd0; p.col = 4'd3; end
      "5": begin p.row = 2'd0; p.col = 4'd4; end
      "6": begin p.row = 2'd0; p.col = 4'd5; end
      "7": begin p.row = 2'd0; p.col = 4'd6; end
      "8": begin p.row = 2'd0; p.col = 4'd7; end
      "9": begin p.row = 2'd0; p.col = 4'd8; end
      "0": begin p.row = 2'd0; p.col = 4'd9; end
      "q": begin p.row = 2'd1; p.col = 4'd0; end
      "w": begin p.row = 2'd1; p.col = 4'd1; end
      "e": begin p.row = 2'd1; p.col = 4'd2; end
      "r": begin p.row = 2'd1; p.col = 4'd3; end
      "t": begin p.row = 2'd1; p.col = 4'd4; end
      "y": begin p.row = 2'd1; p.col = 4'd5; end
      "u": begin p.row = 2'd1; p.col = 4'd6; end
      "i": begin p.row = 2'd1; p.col = 4'd7; end
      "o": begin p.row = 2'd1; p.col = 4'd8; end
      "p": begin p.row = 2'd1; p.col = 4'd9; end
      "a": begin p.row = 2'd2; p.col = 4'd0; end
      "s": begin p.row = 2'd2; p.col = 4'd1; end
      "d": begin p.row = 2'd2; p.col = 4'd2; end
      "f": begin p.row = 2'd2; p.col = 4'd3; end
      "g": begin p.row = 2'd2; p.col = 4'd4; end
      "h": begin p.row = 2'd2; p.col = 4'd5; end
      "j": begin p.row = 2'd2; p.col = 4'd6; end
      "k": begin p.row = 2'd2; p.col = 4'd7; end
      "l": begin p.row = 2'd2; p.col = 4'd8; end
      "z": begin p.row = 2'd3; p.col = 4'd0; end
      "x": begin p.row = 2'd3; p.col = 4'd1; end
      "c": begin p.row = 2'd3; p.col = 4'd2; end
      "v": begin p.row = 2'd3; p.col = 4'd3; end
      "b": begin p.row = 2'd3; p.col = 4'd4; end
      "n": begin p.row = 2'd3; p.col = 4'd5; end
      "m": begin p.row = 2'd3; p.col = 4'd6; end
      default: p.on_keyboard = 1'b0;
    endcase
    return p;
  endfunction

endpackage

/* hdl/pwc_if.sv */
// Request channel interfaces for characters in and results out.
interface pwc_char_if #(parameter int CHAR_BITS = 16);
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] char_code;
  logic                 final_char;

  modport source (output valid, output char_code, output final_char, input ready);
  modport sink   (input valid, input char_code, input final_char, output ready);
endinterface

interface pwc_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] class_mask;
  logic [2:0] class_count;
  logic       repeat_hit;
  logic       sequential_hit;
  logic       walk_hit;

  modport source (output valid, output class_mask, output class_count, output repeat_hit,
                  output sequential_hit, output walk_hit, input ready);
  modport sink   (input valid, input class_mask, input class_count, input repeat_hit,
                  input sequential_hit, input walk_hit, output ready);
endinterface

/* hdl/pwc_front.sv */
// Front end: accepts characters, classifies them and compares them with the previous one.
module pwc_front #(
  parameter int CHAR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid,
  input  logic [CHAR_BITS-1:0] char_code,
  input  logic                 final_char,
  input  logic                 accept,
  output pwc_pkg::item_t       item
);
  import pwc_pkg::*;

  logic [CHAR_BITS-1:0] prior_char;
  logic                 have_prior;
  key_pos_t             prior_key;

  logic [7:0]     low_byte;
  logic           is_ascii;
  logic [3:0]     class_bits;
  key_pos_t       key;
  logic [CHAR_BITS:0] char_ext;
  logic [CHAR_BITS:0] prior_ext;
  logic [4:0]     col_ext;
  logic [4:0]     prior_col_ext;

  // Classify the character
  always_comb begin
    low_byte = char_code[7:0];
    is_ascii = (char_code >> 8) == CHAR_BITS'(0);
    class_bits = '0;
    if (is_ascii && low_byte >= "a" && low_byte <= "z") begin
      class_bits[CLASS_LOWER] = 1'b1;
    end else if (is_ascii && low_byte >= "A" && low_byte <= "Z") begin
      class_bits[CLASS_UPPER] = 1'b1;
    end else if (is_ascii && low_byte >= "0" && low_byte <= "9") begin
      class_bits[CLASS_DIGIT] = 1'b1;
    end else begin
      class_bits[CLASS_SYMBOL] = 1'b1;
    end
    key = key_lookup(low_byte);
    key.on_keyboard = key.on_keyboard & is_ascii;
  end

  // Compare with the previous character, no wrap at the top of the code range
  always_comb begin
    char_ext      = {1'b0, char_code};
    prior_ext     = {1'b0, prior_char};
    col_ext       = {1'b0, key.col};
    prior_col_ext = {1'b0, prior_key.col};
    item.same       = have_prior && (char_code == prior_char);
    item.rise       = have_prior && (char_ext == prior_ext + (CHAR_BITS+1)'(1));
    item.fall       = have_prior && (char_ext + (CHAR_BITS+1)'(1) == prior_ext);
    item.adjacent   = key.on_keyboard && prior_key.on_keyboard &&
                      (key.row == prior_key.row) &&
                      ((col_ext == prior_col_ext + 5'd1) || (col_ext + 5'd1 == prior_col_ext));
    item.class_bits = class_bits;
    item.final_char = final_char;
  end

  // Track the previous character; drop it after the last one of a password
  always_ff @(posedge clk) begin
    if (rst) begin
      prior_char <= '0;
      have_prior <= 1'b0;
      prior_key  <= '0;
    end else if (valid && accept) begin
      if (final_char) begin
        prior_char <= '0;
        have_prior <= 1'b0;
        prior_key  <= '0;
      end else begin
        prior_char <= char_code;
        have_prior <= 1'b1;
        prior_key.on_keyboard <= key.on_keyboard;
        if (key.on_keyboard) begin
          prior_key.row <= key.row;
          prior_key.col <= key.col;
        end
      end
    end
  end

endmodule

/* hdl/pwc_queue.sv */
// Short queue of classified characters between the front and the back.
module pwc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pwc_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output pwc_pkg::item_t pop_item
);
  import pwc_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  item_t               slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  logic do_push;
  logic do_pop;

  assign full      = count == CNT_BITS'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = slots[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

endmodule

/* hdl/pwc_back.sv */
// Back end: run counters, sticky flags, class mask and the result register.
module pwc_back #(
  parameter int RUN_COUNT_BITS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  pwc_pkg::cfg_t  cfg,
  input  logic           item_valid,
  input  pwc_pkg::item_t item,
  output logic           item_pop,
  pwc_result_if.source   result
);
  import pwc_pkg::*;

  localparam int CMP_BITS = (RUN_COUNT_BITS > CFG_DATA_BITS) ? RUN_COUNT_BITS : CFG_DATA_BITS;
  localparam logic [RUN_COUNT_BITS-1:0] RUN_MAX = {RUN_COUNT_BITS{1'b1}};
  localparam logic [RUN_COUNT_BITS-1:0] RUN_ONE = RUN_COUNT_BITS'(1);

  logic [RUN_COUNT_BITS-1:0] same_run;
  logic [RUN_COUNT_BITS-1:0] rise_run;
  logic [RUN_COUNT_BITS-1:0] fall_run;
  logic [RUN_COUNT_BITS-1:0] key_run;
  logic [3:0]                seen_classes;
  logic [2:0]                hit_flags;

  logic [RUN_COUNT_BITS-1:0] same_run_next;
  logic [RUN_COUNT_BITS-1:0] rise_run_next;
  logic [RUN_COUNT_BITS-1:0] fall_run_next;
  logic [RUN_COUNT_BITS-1:0] key_run_next;
  logic [3:0]                seen_classes_next;
  logic [2:0]                hit_flags_next;
  logic                      seq_enabled;
  logic                      walk_enabled;

  function automatic logic [RUN_COUNT_BITS-1:0] sat_inc(input logic [RUN_COUNT_BITS-1:0] v);
    return (v == RUN_MAX) ? RUN_MAX : v + RUN_ONE;
  endfunction

  // Take an item whenever the result register is free or being emptied
  assign item_pop = item_valid && (!result.valid || result.ready);

  // Update runs and flags for the item at the head of the queue
  always_comb begin
    same_run_next = item.same ? sat_inc(same_run) : RUN_ONE;
    rise_run_next = item.rise ? sat_inc(rise_run) : RUN_ONE;
    fall_run_next = (item.fall && !item.rise) ? sat_inc(fall_run) : RUN_ONE;
    key_run_next  = item.adjacent ? sat_inc(key_run) : RUN_ONE;
    seen_classes_next = seen_classes | item.class_bits;
    seq_enabled  = cfg.sequential_min >= CFG_DATA_BITS'(2);
    walk_enabled = cfg.walk_min >= CFG_DATA_BITS'(2);
    hit_flags_next = hit_flags;
    if (item.same && (CMP_BITS'(same_run_next) > CMP_BITS'(cfg.max_repeat))) begin
      hit_flags_next[0] = 1'b1;
    end
    if (seq_enabled &&
        ((CMP_BITS'(rise_run_next) >= CMP_BITS'(cfg.sequential_min)) ||
         (CMP_BITS'(fall_run_next) >= CMP_BITS'(cfg.sequential_min)))) begin
      hit_flags_next[1] = 1'b1;
    end
    if (walk_enabled && (CMP_BITS'(key_run_next) >= CMP_BITS'(cfg.walk_min))) begin
      hit_flags_next[2] = 1'b1;
    end
  end

  // Hold the password state; clear it after the last character
  always_ff @(posedge clk) begin
    if (rst) begin
      same_run     <= RUN_ONE;
      rise_run     <= RUN_ONE;
      fall_run     <= RUN_ONE;
      key_run      <= RUN_ONE;
      seen_classes <= '0;
      hit_flags    <= '0;
    end else if (item_pop) begin
      if (item.final_char) begin
        same_run     <= RUN_ONE;
        rise_run     <= RUN_ONE;
        fall_run     <= RUN_ONE;
        key_run      <= RUN_ONE;
        seen_classes <= '0;
        hit_flags    <= '0;
      end else begin
        same_run     <= same_run_next;
        rise_run     <= rise_run_next;
        fall_run     <= fall_run_next;
        key_run      <= key_run_next;
        seen_classes <= seen_classes_next;
        hit_flags    <= hit_flags_next;
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (item_pop) begin
      result.valid <= item.final_char;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (item_pop && item.final_char) begin
      result.class_mask     <= seen_classes_next;
      result.class_count    <= {2'b00, seen_classes_next[0]} + {2'b00, seen_classes_next[1]} +
                               {2'b00, seen_classes_next[2]} + {2'b00, seen_classes_next[3]};
      result.repeat_hit     <= hit_flags_next[0];
      result.sequential_hit <= hit_flags_next[1];
      result.walk_hit       <= hit_flags_next[2];
    end
  end

endmodule

/* hdl/password_pattern_checker.sv */
// Top level of the password pattern checker: configuration registers, front, queue and back.
//
//   channel     direction  payload                                       request moves
//   char_in     in         char_code, final_char                         one character
//   result_out  out        class_mask, class_count, repeat/seq/walk hit  one password result
//   cfg_*       in         cfg_index, cfg_data (write only)              one register write
//
// One character per cycle sustained while results are taken; a result is registered once
// its last character is taken, through the queue and the result register in the back end.
// Synchronous reset restores the register defaults and clears all password state.
// A stalled result holds the back end; the two-entry queue then fills and char_in.ready drops.
module password_pattern_checker #(
  parameter int RUN_COUNT_BITS = 8,
  parameter int CHAR_BITS      = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [pwc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [pwc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  pwc_char_if.sink                             char_in,
  pwc_result_if.source                         result_out
);
  import pwc_pkg::*;

  cfg_t  cfg;
  item_t front_item;
  item_t head_item;
  logic  queue_full;
  logic  queue_not_empty;
  logic  head_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_repeat     <= MAX_REPEAT_RESET;
      cfg.sequential_min <= SEQUENTIAL_MIN_RESET;
      cfg.walk_min       <= WALK_MIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_REPEAT:     cfg.max_repeat     <= cfg_data;
        REG_SEQUENTIAL_MIN: cfg.sequential_min <= cfg_data;
        REG_WALK_MIN:       cfg.walk_min       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign char_in.ready = !queue_full;

  pwc_front #(
    .CHAR_BITS(CHAR_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .valid     (char_in.valid),
    .char_code (char_in.char_code),
    .final_char(char_in.final_char),
    .accept    (char_in.ready),
    .item      (front_item)
  );

  pwc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (char_in.valid),
    .push_item(front_item),
    .full     (queue_full),
    .pop      (head_pop),
    .not_empty(queue_not_empty),
    .pop_item (head_item)
  );

  pwc_back #(
    .RUN_COUNT_BITS(RUN_COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item_valid(queue_not_empty),
    .item      (head_item),
    .item_pop  (head_pop),
    .result    (result_out)
  );

endmodule
